@@ rtl/core/tcw_pkg.sv @@
// Shared types, geometry constants and register codes for the text console writer.
// Depends on nothing; every other file of the block but tcw_ram imports it.
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELL_W = $clog2(CELLS);

  // Fixed widths of the transfer fields.
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int IN_ROW_W   = 5;
  localparam int IN_COL_W   = 7;
  localparam int FUNC_W     = 2;
  localparam int CURSOR_W   = 11;
  localparam int CELL_DATA_W = CHAR_W + ATTR_W;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Character codes.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_DEFAULT_ATTR = 1'b0;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Function codes as they arrive on the stream.
  localparam logic [FUNC_W-1:0] FUNC_PUT_CURSOR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUT_AT     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 2'd3;

  typedef enum logic [1:0] {
    CMD_PUT_CURSOR = 2'd0,
    CMD_PUT_AT     = 2'd1,
    CMD_READ       = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_kind_e;

  // A classified command as it sits in the queue.
  typedef struct packed {
    cmd_kind_e           kind;
    logic                newline;
    logic [CHAR_W-1:0]   character;
    logic [ATTR_W-1:0]   attribute;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
  } cmd_t;

  // One result item, packed with the cursor index in the lowest bits.
  typedef struct packed {
    logic                scrolled;
    logic [ATTR_W-1:0]   read_attribute;
    logic [CHAR_W-1:0]   read_character;
    logic [CURSOR_W-1:0] cursor_index;
  } res_t;

endpackage

@@ rtl/core/tcw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the character cell store.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tcw_front.sv @@
// Front end: takes stream transfers, saturates the position, resolves the default attribute and classifies the command.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_TDATA_W-1:0] s_tdata_i,
  input  logic [FUNC_W-1:0]     s_tuser_i,
  input  logic                  hold_i,
  input  logic [ATTR_W-1:0]     default_attr_i,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  input  logic                  cmd_ready_i
);

  logic [CHAR_W-1:0]   in_char;
  logic [ATTR_W-1:0]   in_attr;
  logic [IN_ROW_W-1:0] in_row;
  logic [IN_COL_W-1:0] in_col;

  assign in_char = s_tdata_i[CHAR_W-1:0];
  assign in_attr = s_tdata_i[CHAR_W+ATTR_W-1:CHAR_W];
  assign in_row  = s_tdata_i[CHAR_W+ATTR_W+IN_ROW_W-1:CHAR_W+ATTR_W];
  assign in_col  = s_tdata_i[CHAR_W+ATTR_W+IN_ROW_W+IN_COL_W-1:CHAR_W+ATTR_W+IN_ROW_W];

  always_comb begin
    unique case (s_tuser_i)
      FUNC_PUT_CURSOR: cmd_o.kind = CMD_PUT_CURSOR;
      FUNC_PUT_AT:     cmd_o.kind = CMD_PUT_AT;
      FUNC_READ:       cmd_o.kind = CMD_READ;
      FUNC_CLEAR:      cmd_o.kind = CMD_CLEAR;
      default:         cmd_o.kind = CMD_CLEAR;
    endcase
    cmd_o.newline   = (in_char == NEWLINE_CODE);
    cmd_o.character = in_char;
    // A zero attribute selects the configured default.
    cmd_o.attribute = (in_attr == '0) ? default_attr_i : in_attr;
    // Positions beyond the screen clamp to the last row or column.
    cmd_o.row    = (int'(in_row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(in_row);
    cmd_o.column = (int'(in_col) >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(in_col);
  end

  assign cmd_valid_o = s_tvalid_i & ~hold_i;
  assign s_tready_o  = cmd_ready_i & ~hold_i;

endmodule

@@ rtl/core/tcw_queue.sv @@
// Short command queue that decouples the front end from the cell engine.
// Depends on tcw_pkg.
module tcw_queue import tcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/tcw_back.sv @@
// Cell engine: carries out commands against the cell store, owns cursor and scroll base.
// Depends on tcw_pkg and tcw_ram.
module tcw_back import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ATTR_W-1:0] default_attr_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              init_busy_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_CLEAR  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  top_q, top_d;
  logic [CELL_W-1:0] sweep_q, sweep_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  logic                   ram_we;
  logic [CELL_W-1:0]      ram_waddr;
  logic [CELL_DATA_W-1:0] ram_wdata;
  logic [CELL_W-1:0]      ram_raddr;
  logic [CELL_DATA_W-1:0] ram_rdata;

  logic                   out_free;
  logic [ROW_W-1:0]       pos_row;
  logic [COL_W-1:0]       pos_col;
  logic [ROW_W:0]         prow_sum;
  logic [ROW_W-1:0]       prow;
  logic [CELL_W-1:0]      phys_addr;
  logic [ROW_W:0]         next_row_w;
  logic [COL_W-1:0]       next_col;
  logic                   wrap;
  logic [CURSOR_W-1:0]    next_index;
  logic [CURSOR_W-1:0]    cur_index;
  logic [CELL_W-1:0]      top_base;
  logic [CELL_DATA_W-1:0] blank;

  assign out_free = ~out_valid_q | res_ready_i;
  assign blank    = {default_attr_i, BLANK_CODE};

  // Addressed cell: the cursor for a write at the cursor, else the given position.
  assign pos_row = (cmd_i.kind == CMD_PUT_CURSOR) ? cur_row_q : cmd_i.row;
  assign pos_col = (cmd_i.kind == CMD_PUT_CURSOR) ? cur_col_q : cmd_i.column;

  // Logical row to physical row through the rotating top-row base.
  assign prow_sum  = {1'b0, pos_row} + {1'b0, top_q};
  assign prow      = (int'(prow_sum) >= ROWS) ? ROW_W'(int'(prow_sum) - ROWS)
                                              : prow_sum[ROW_W-1:0];
  assign phys_addr = CELL_W'(prow) * CELL_W'(COLUMNS) + CELL_W'(pos_col);
  assign top_base  = CELL_W'(top_q) * CELL_W'(COLUMNS);

  // Cursor after a write: newline or end of row moves to the next row's start.
  always_comb begin
    if (cmd_i.newline || (pos_col == COL_W'(COLUMNS - 1))) begin
      next_row_w = {1'b0, pos_row} + 1'b1;
      next_col   = '0;
    end else begin
      next_row_w = {1'b0, pos_row};
      next_col   = pos_col + 1'b1;
    end
  end

  assign wrap       = (int'(next_row_w) == ROWS);
  assign next_index = CURSOR_W'(next_row_w) * CURSOR_W'(COLUMNS) + CURSOR_W'(next_col);
  assign cur_index  = CURSOR_W'(cur_row_q) * CURSOR_W'(COLUMNS) + CURSOR_W'(cur_col_q);

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    top_d       = top_q;
    sweep_d     = sweep_q;
    out_valid_d = out_valid_q & ~res_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = sweep_q;
    ram_wdata   = blank;
    ram_raddr   = phys_addr;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {RESET_ATTR, BLANK_CODE};
        if (sweep_q == CELL_W'(CELLS - 1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_CLEAR: begin
              cur_row_d = '0;
              cur_col_d = '0;
              top_d     = '0;
              sweep_d   = '0;
              state_d   = ST_CLEAR;
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
            CMD_PUT_CURSOR, CMD_PUT_AT: begin
              if (!cmd_i.newline) begin
                ram_we    = 1'b1;
                ram_waddr = phys_addr;
                ram_wdata = {cmd_i.attribute, cmd_i.character};
              end
              if (wrap) begin
                cur_row_d = ROW_W'(ROWS - 1);
                cur_col_d = '0;
                sweep_d   = '0;
                state_d   = ST_SCROLL;
              end else begin
                cur_row_d   = next_row_w[ROW_W-1:0];
                cur_col_d   = next_col;
                out_valid_d = 1'b1;
                out_d       = '{scrolled: 1'b0, read_attribute: '0,
                                read_character: '0, cursor_index: next_index};
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_READ: begin
        out_valid_d = 1'b1;
        out_d       = '{scrolled: 1'b0,
                        read_attribute: ram_rdata[CELL_DATA_W-1:CHAR_W],
                        read_character: ram_rdata[CHAR_W-1:0],
                        cursor_index: cur_index};
        state_d     = ST_IDLE;
      end

      ST_SCROLL: begin
        // Blank the old top physical row, which becomes the new bottom row.
        ram_we    = 1'b1;
        ram_waddr = top_base + sweep_q;
        if (sweep_q == CELL_W'(COLUMNS - 1)) begin
          top_d       = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
          sweep_d     = '0;
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_d       = '{scrolled: 1'b1, read_attribute: '0, read_character: '0,
                          cursor_index: CURSOR_W'((ROWS - 1) * COLUMNS)};
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      ST_CLEAR: begin
        ram_we = 1'b1;
        if (sweep_q == CELL_W'(CELLS - 1)) begin
          sweep_d     = '0;
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_d       = '{scrolled: 1'b0, read_attribute: '0, read_character: '0,
                          cursor_index: '0};
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      top_q       <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      top_q       <= top_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  tcw_ram #(
    .WIDTH (CELL_DATA_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign init_busy_o = (state_q == ST_INIT);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer: character-cell screen with cursor, scrolling and clear.
// A write passes the queue and the output register; a read adds the read state, a scrolling
// write a one-row sweep, a clear a full sweep. Writes sustain one per cycle while results
// are taken; the engine takes no command while a read waits on its data, as the cell RAM
// has a single read port with registered read data. After reset the RAM is swept to blanks,
// one cell a cycle, taking no command meanwhile; configuration writes are taken throughout.
module text_console_writer import tcw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // Command stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata, lowest bit up: character[7:0], attribute[15:8], row[20:16], column[27:21],
  // zero padding[31:28].
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0] (write at cursor, write at position, read cell, clear screen).
  input  logic [FUNC_W-1:0]      s_axis_tuser,

  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata, lowest bit up: cursor_index[10:0], read_character[18:11],
  // read_attribute[26:19], scrolled[27], zero padding[31:28].
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,

  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [ATTR_W-1:0] default_attr_q, default_attr_d;
  logic              reg_hit;

  logic              init_busy;
  logic              front_valid, front_ready;
  cmd_t              front_cmd;
  logic              queue_valid, queue_ready;
  cmd_t              queue_cmd;
  res_t              result;

  // The only register answers at byte addresses zero to three; addresses four to seven read
  // as zero and ignore writes.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_DEFAULT_ATTR);
  assign prdata  = reg_hit ? APB_DATA_W'(default_attr_q) : '0;

  always_comb begin
    default_attr_d = default_attr_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      default_attr_d = pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_attr_q <= RESET_ATTR;
    end else begin
      default_attr_q <= default_attr_d;
    end
  end

  // The front end decodes each transfer and resolves the default attribute, so the
  // queue holds commands that the cell engine can act on directly.
  tcw_front u_front (
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_o     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .hold_i         (init_busy),
    .default_attr_i (default_attr_q),
    .cmd_valid_o    (front_valid),
    .cmd_o          (front_cmd),
    .cmd_ready_i    (front_ready)
  );

  // The queue lets new commands arrive while the engine sweeps a row or the whole
  // screen, or while a result waits to be taken.
  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_cmd_o    (queue_cmd)
  );

  // The engine owns the cell RAM, cursor and top-row base, and holds each result in
  // an output register until the downstream side takes it.
  tcw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .default_attr_i (default_attr_q),
    .cmd_valid_i    (queue_valid),
    .cmd_ready_o    (queue_ready),
    .cmd_i          (queue_cmd),
    .init_busy_o    (init_busy),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_o          (result)
  );

  assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer. It drives command transfers and APB writes.
// It predicts every result transfer and compares the result field by field.
// Depends on tcw_pkg and the text_console_writer RTL.
module tb import tcw_pkg::*; ();

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int MAX_IDLE        = 5;
  localparam int HOLD_OFF_CYCLES = 300;
  // The wait spans a scrolling write, the slowest command short of a clear.
  localparam int DRAIN_CYCLES    = COLUMNS + 20;
  localparam int PRINT_LIMIT     = 40;
  // Even a run made only of clears, with every gap and stall at its longest, ends well inside
  // this limit.
  localparam int TIMEOUT_NS      = 25_000_000;

  // The register lies at byte address 4*index. Index one is unmapped, so a write to it must be
  // ignored.
  localparam logic [APB_ADDR_W-1:0] DEFAULT_ATTR_ADDR = {REG_DEFAULT_ATTR, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR     = 3'b100;
  localparam int CMD_BITS = CHAR_W + ATTR_W + IN_ROW_W + IN_COL_W;

  // One command as it travels on the input stream.
  typedef struct packed {
    cmd_kind_e              kind;
    logic [CHAR_W-1:0]      character;
    logic [ATTR_W-1:0]      attribute;
    logic [IN_ROW_W-1:0]    row;
    logic [IN_COL_W-1:0]    column;
  } console_cmd_t;

  // The scoreboard keeps its own copy of the screen. That copy holds the cells, the cursor and
  // the rotating top-row base. Each accepted command is applied to the copy at once, and the
  // expected result is queued until the block returns its result.
  class screen_scoreboard;
    logic [CELL_DATA_W-1:0] cells [CELLS];
    int unsigned            cursor_cell;
    int unsigned            top_row;
    logic [ATTR_W-1:0]      default_attr;
    res_t                   due_results [$];
    int unsigned            mismatches;

    function new();
      default_attr = RESET_ATTR;
      mismatches   = 0;
      blank_screen();
    endfunction

    function void blank_screen();
      foreach (cells[i]) cells[i] = {default_attr, BLANK_CODE};
      top_row     = 0;
      cursor_cell = 0;
    endfunction

    // Logical cell to physical slot. Screen row 0 is the physical row top_row.
    function int unsigned slot(int unsigned logical);
      return ((logical / COLUMNS + top_row) % ROWS) * COLUMNS + logical % COLUMNS;
    endfunction

    // The old top row becomes the blank bottom row.
    function void scroll_up();
      for (int c = 0; c < COLUMNS; c++) cells[top_row * COLUMNS + c] = {default_attr, BLANK_CODE};
      top_row = (top_row + 1) % ROWS;
    endfunction

    function void apply_command(console_cmd_t cmd);
      res_t                   want;
      int unsigned            row, col, pos, next;
      logic [ATTR_W-1:0]      attr;
      logic [CELL_DATA_W-1:0] stored;
      want = '0;
      // An out-of-range row or column saturates to the last one.
      row  = (cmd.row >= ROWS) ? ROWS - 1 : cmd.row;
      col  = (cmd.column >= COLUMNS) ? COLUMNS - 1 : cmd.column;
      case (cmd.kind)
        CMD_CLEAR: blank_screen();
        CMD_READ: begin
          stored = cells[slot(row * COLUMNS + col)];
          want.read_character = stored[CHAR_W-1:0];
          want.read_attribute = stored[CELL_DATA_W-1:CHAR_W];
        end
        default: begin
          pos  = (cmd.kind == CMD_PUT_CURSOR) ? cursor_cell % CELLS : row * COLUMNS + col;
          attr = (cmd.attribute == '0) ? default_attr : cmd.attribute;
          // A newline stores nothing. It moves the cursor to the start of the next row, from
          // the cursor and from an explicit position alike.
          if (cmd.character == NEWLINE_CODE) begin
            next = (pos / COLUMNS + 1) * COLUMNS;
          end else begin
            cells[slot(pos)] = {attr, cmd.character};
            next = pos + 1;
          end
          if (next >= CELLS) begin
            scroll_up();
            next = (ROWS - 1) * COLUMNS;
            want.scrolled = 1'b1;
          end
          cursor_cell = next;
        end
      endcase
      want.cursor_index = CURSOR_W'(cursor_cell);
      due_results.push_back(want);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata);
      res_t got, want;
      got = tdata[$bits(res_t)-1:0];
      if (due_results.size() == 0) begin
        report($sformatf("result %h arrived with no command outstanding", tdata));
        return;
      end
      want = due_results.pop_front();
      if (got.cursor_index !== want.cursor_index)
        report($sformatf("cursor_index %0d, expected %0d", got.cursor_index, want.cursor_index));
      if (got.read_character !== want.read_character)
        report($sformatf("read_character %h, expected %h", got.read_character,
                         want.read_character));
      if (got.read_attribute !== want.read_attribute)
        report($sformatf("read_attribute %h, expected %h", got.read_attribute,
                         want.read_attribute));
      if (got.scrolled !== want.scrolled)
        report($sformatf("scrolled %b, expected %b", got.scrolled, want.scrolled));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [FUNC_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel, penable, pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  screen_scoreboard sb;

  // Each flag is set by the stimulus. tx_steady and rx_steady switch idling off on one side.
  // rx_hold_request asks the receiver for one long hold-off.
  bit tx_steady;
  bit rx_steady;
  bit rx_hold_request;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  text_console_writer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Every result transfer is checked at the rising edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Receiver. Before each result it stalls for a random number of cycles. On request it holds
  // off once for a long stretch, so that the block's queue fills and the input stalls.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_request) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        rx_hold_request = 1'b0;
      end
      stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic console_cmd_t make_cmd(cmd_kind_e kind, logic [CHAR_W-1:0] character,
                                            logic [ATTR_W-1:0] attribute,
                                            logic [IN_ROW_W-1:0] row,
                                            logic [IN_COL_W-1:0] column);
    console_cmd_t c;
    c.kind      = kind;
    c.character = character;
    c.attribute = attribute;
    c.row       = row;
    c.column    = column;
    return c;
  endfunction

  // Random commands are mostly writes and reads. Clears are rare, because each one walks the
  // whole store. Positions are biased to the bottom-right corner, so that scrolling comes
  // often. A fifth of positions span the full field width, which exercises saturation.
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      c.kind = CMD_PUT_CURSOR;
    else if (pick < 67) c.kind = CMD_PUT_AT;
    else if (pick < 99) c.kind = CMD_READ;
    else                c.kind = CMD_CLEAR;
    c.character = ($urandom_range(0, 4) == 0) ? NEWLINE_CODE : CHAR_W'($urandom);
    c.attribute = ($urandom_range(0, 3) == 0) ? '0 : ATTR_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        c.row    = IN_ROW_W'($urandom);
        c.column = IN_COL_W'($urandom);
      end
      2, 3: begin
        c.row    = IN_ROW_W'(ROWS - 1);
        c.column = IN_COL_W'($urandom_range(COLUMNS - 4, COLUMNS - 1));
      end
      default: begin
        c.row    = IN_ROW_W'($urandom_range(0, ROWS - 1));
        c.column = IN_COL_W'($urandom_range(0, COLUMNS - 1));
      end
    endcase
    return c;
  endfunction

  // Entered and left at a falling edge. With no gap drawn, tvalid stays high, and the next
  // command follows straight on.
  task automatic send_cmd(console_cmd_t c);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(IN_TDATA_W - CMD_BITS){1'b0}}, c.column, c.row, c.attribute, c.character};
    s_axis_tuser  = c.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_command(c);
    @(negedge clk_i);
  endtask

  // Stops offering commands and waits until every expected result has come back.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // An APB write: a setup cycle, then an access cycle, which completes at the edge where
  // pready is high.
  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == DEFAULT_ATTR_ADDR) sb.default_attr = data[ATTR_W-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic run_random(int unsigned count, bit pause_midway);
    for (int unsigned n = 0; n < count; n++) begin
      // The sender pauses here until the block has delivered every result.
      if (pause_midway && n == count / 2) wait_drained();
      send_cmd(random_cmd());
    end
    wait_drained();
  endtask

  // The directed commands run with the reset attribute. The first reads see the blanks that
  // reset leaves. Then come writes at both ends of every field, and newlines at the cursor
  // and at an explicit position. Writes past the last cell scroll, saturated positions are
  // used, and the screen is cleared.
  task automatic run_directed();
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd31, 7'd127));
    send_cmd(make_cmd(CMD_PUT_CURSOR, 8'h41, 8'h00, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_PUT_CURSOR, 8'hFF, 8'hFF, 5'd31, 7'd127));
    send_cmd(make_cmd(CMD_PUT_CURSOR, 8'h00, 8'h01, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_PUT_CURSOR, NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_PUT_AT, 8'h5A, 8'h80, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_PUT_AT, 8'h71, 8'h00, 5'd5, 7'd79));
    send_cmd(make_cmd(CMD_PUT_AT, NEWLINE_CODE, 8'h22, 5'd10, 7'd40));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd1));
    send_cmd(make_cmd(CMD_PUT_AT, 8'h45, 8'h3C, 5'd31, 7'd127));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd23, 7'd79));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd24, 7'd79));
    send_cmd(make_cmd(CMD_PUT_CURSOR, NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_PUT_AT, NEWLINE_CODE, 8'h00, 5'd24, 7'd0));
    send_cmd(make_cmd(CMD_PUT_CURSOR, 8'h78, 8'h00, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd24, 7'd0));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd24, 7'd127));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd25, 7'd3));
    send_cmd(make_cmd(CMD_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd24, 7'd79));
    send_cmd(make_cmd(CMD_PUT_CURSOR, 8'h42, 8'h00, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    send_cmd(make_cmd(CMD_PUT_AT, NEWLINE_CODE, 8'h00, 5'd24, 7'd79));
    wait_drained();
  endtask

  initial begin
    sb              = new();
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    rx_hold_request = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = FUNC_PUT_CURSOR;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // The block sweeps its store after reset. Commands wait on tready until the sweep is
    // over, and the register keeps its reset value until the directed part is done.
    run_directed();

    // Phase: a write to the unmapped register must change nothing. Then attribute zero,
    // with idling on both sides and a pause to let the block drain halfway through.
    apb_write(UNMAPPED_ADDR, 32'h0000_0055);
    apb_write(DEFAULT_ATTR_ADDR, 32'h0000_0000);
    run_random(200, 1'b1);

    // Phase: attribute at its top value. The sender streams with no gaps while the receiver
    // holds off, so that the input side has to stall.
    apb_write(DEFAULT_ATTR_ADDR, 32'h0000_00FF);
    tx_steady       = 1'b1;
    rx_hold_request = 1'b1;
    run_random(150, 1'b0);
    tx_steady = 1'b0;

    // Phase: a random attribute, with no idling on either side.
    apb_write(DEFAULT_ATTR_ADDR, APB_DATA_W'($urandom_range(1, 254)));
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_random(200, 1'b0);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // Phase: the reset value again, with idling restored.
    apb_write(DEFAULT_ATTR_ADDR, APB_DATA_W'(RESET_ATTR));
    run_random(250, 1'b1);

    // Any result that still comes now is a stray one, and the monitor flags it.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("text_console_writer regression: fail");
    $finish;
  end

endmodule
